>>> src/fuzzy_pd_controller_top_macros.svh
// ----------------------------------------------------------------------------
// Fuzzy PD controller assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef FUZZY_PD_CONTROLLER_TOP_MACROS_SVH
`define FUZZY_PD_CONTROLLER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/fpd_pkg.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller package
// Shared widths, breakpoints, rule table and the types passed between parts.
// ----------------------------------------------------------------------------
`default_nettype none

package fpd_pkg;

    // Input and weight formats.
    localparam int IN_W      = 16;
    localparam int WF        = 15;
    localparam int W_W       = WF + 1;
    localparam logic [W_W-1:0] ONE_W = W_W'(1) << WF;

    // Table sizes.
    localparam int N_ERR    = 7;
    localparam int N_RATE   = 5;
    localparam int N_LEVELS = 7;
    localparam int N_CELLS  = 4;
    localparam int LEVEL_W  = 8;
    localparam int DRIVE_W  = 16;
    localparam int CODE_W   = 3;
    localparam int SEG_W    = 3;
    localparam int REG_IDX_W = 3;
    localparam int OUT_FRAC = 8;

    // Breakpoints in Q.8.
    localparam logic signed [IN_W-1:0] ERR_PTS [N_ERR] =
        '{-16'sd6144, -16'sd3072, -16'sd1536, 16'sd0, 16'sd1536, 16'sd3072, 16'sd6144};
    localparam logic signed [IN_W-1:0] RATE_PTS [N_RATE] =
        '{-16'sd1664, -16'sd768, 16'sd0, 16'sd768, 16'sd1664};

    // Segment widths are 3 or 7 times a power of two. The distance to the upper
    // breakpoint is shifted so that only a division by 3 or 7 is left.
    localparam int ERR_D_W       = 12;
    localparam int RATE_D_W      = 10;
    localparam int ERR_SH_WIDE   = 5;
    localparam int ERR_SH_NARROW = 6;
    localparam int RATE_SH_OUTER = 8;
    localparam int RATE_SH_INNER = 7;
    localparam int NUM_W         = 18;

    // Reciprocals: floor(n/3) = (n*RECIP3) >> SH3 for n < 2^19,
    // floor(n/7) = (n*RECIP7) >> SH7 for n < 349525.
    localparam int RECIP_W = 19;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP3 = 19'd174763;
    localparam logic [RECIP_W-1:0] RECIP7 = 19'd299594;
    localparam int SH3 = 19;
    localparam int SH7 = 21;

    // Rule table: error row by rate column gives an output level code.
    localparam logic [CODE_W-1:0] RULE_MAP [N_ERR][N_RATE] = '{
        '{3'd1, 3'd1, 3'd1, 3'd0, 3'd0},
        '{3'd4, 3'd2, 3'd1, 3'd0, 3'd0},
        '{3'd6, 3'd4, 3'd1, 3'd1, 3'd0},
        '{3'd3, 3'd3, 3'd0, 3'd3, 3'd3},
        '{3'd0, 3'd1, 3'd1, 3'd4, 3'd6},
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd4},
        '{3'd0, 3'd0, 3'd1, 3'd1, 3'd1}
    };

    localparam logic [LEVEL_W-1:0] LEVEL_RESET [N_LEVELS] =
        '{8'd0, 8'd15, 8'd20, 8'd35, 8'd50, 8'd80, 8'd120};

    // Queue depths.
    localparam int MID_DEPTH = 8;
    localparam int OUT_DEPTH = 2;

    // One classified request: four rule cells with codes and strengths.
    typedef struct packed {
        logic [N_CELLS-1:0][CODE_W-1:0] code;
        logic [N_CELLS-1:0][W_W-1:0]    strength;
    } fpd_item_t;

    // One configuration write.
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] index;
        logic [LEVEL_W-1:0]   data;
    } cfg_write_t;

endpackage

`default_nettype wire

>>> src/fpd_fifo.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller queue
// Small register queue with a combinational head, used between the parts.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty,
    output logic             full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Handshake qualification and pointer stepping.
    always_comb
    begin
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

>>> src/fpd_front.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller front end
// Fuzzifies error and rate, picks the four rule cells and their strengths.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [fpd_pkg::IN_W-1:0]   error,
    input  logic signed [fpd_pkg::IN_W-1:0]   error_rate,
    output logic                              out_push,
    output fpd_pkg::fpd_item_t                out_item
);
    import fpd_pkg::*;

    // Stage 1 signals.
    logic [SEG_W-1:0]        e_seg, r_seg;
    logic                    e_below, e_above, r_below, r_above, r_div7;
    logic signed [IN_W-1:0]  e_hi, r_hi;
    logic signed [IN_W:0]    e_diff, r_diff;
    logic [NUM_W-1:0]        e_num, r_num;

    logic                    v1_reg;
    logic [SEG_W-1:0]        e_seg1_reg, r_seg1_reg;
    logic                    e_below1_reg, e_above1_reg, r_below1_reg, r_above1_reg;
    logic                    r_div71_reg;
    logic [NUM_W-1:0]        e_num1_reg, r_num1_reg;

    // Stage 2 signals.
    logic                    v2_reg;
    logic [SEG_W-1:0]        e_seg2_reg, r_seg2_reg;
    logic                    e_below2_reg, e_above2_reg, r_below2_reg, r_above2_reg;
    logic                    r_div72_reg;
    logic [PROD_W-1:0]       e_prod_reg, r_prod_reg;

    // Stage 3 signals.
    logic [W_W-1:0]          e_w0, e_w1, r_w0, r_w1;
    logic [N_CELLS-1:0][W_W-1:0]    s_calc;
    logic [N_CELLS-1:0][CODE_W-1:0] c_calc;
    logic                    v3_reg;
    logic [N_CELLS-1:0][W_W-1:0]    s3_reg;
    logic [N_CELLS-1:0][CODE_W-1:0] c3_reg;
    logic [N_CELLS-1:0][W_W-1:0]    s_kept;

    // Segment choice and distance to the upper breakpoint of that segment.
    always_comb
    begin
        e_seg = '0;
        for (int j = 1; j < N_ERR - 1; j++)
        begin
            if (error > ERR_PTS[j])
            begin
                e_seg = e_seg + 1'b1;
            end
        end
        r_seg = '0;
        for (int j = 1; j < N_RATE - 1; j++)
        begin
            if (error_rate > RATE_PTS[j])
            begin
                r_seg = r_seg + 1'b1;
            end
        end
        e_below = (error <= ERR_PTS[0]);
        e_above = (error >= ERR_PTS[N_ERR-1]);
        r_below = (error_rate <= RATE_PTS[0]);
        r_above = (error_rate >= RATE_PTS[N_RATE-1]);
        e_hi    = ERR_PTS[e_seg + 1'b1];
        r_hi    = RATE_PTS[r_seg + 1'b1];
        e_diff  = (IN_W+1)'(e_hi) - (IN_W+1)'(error);
        r_diff  = (IN_W+1)'(r_hi) - (IN_W+1)'(error_rate);
        // Outer error segments are twice as wide as the inner ones.
        if (e_seg == '0 || e_seg == SEG_W'(N_ERR - 2))
        begin
            e_num = NUM_W'(e_diff[ERR_D_W-1:0]) << ERR_SH_WIDE;
        end
        else
        begin
            e_num = NUM_W'(e_diff[ERR_D_W-1:0]) << ERR_SH_NARROW;
        end
        // Outer rate segments are 3.5 wide and need a division by 7.
        r_div7 = (r_seg == '0 || r_seg == SEG_W'(N_RATE - 2));
        if (r_div7)
        begin
            r_num = NUM_W'(r_diff[RATE_D_W-1:0]) << RATE_SH_OUTER;
        end
        else
        begin
            r_num = NUM_W'(r_diff[RATE_D_W-1:0]) << RATE_SH_INNER;
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1 and stage 2 payload: reciprocal multiply.
    always_ff @(posedge clk)
    begin
        e_seg1_reg   <= e_seg;
        r_seg1_reg   <= r_seg;
        e_below1_reg <= e_below;
        e_above1_reg <= e_above;
        r_below1_reg <= r_below;
        r_above1_reg <= r_above;
        r_div71_reg  <= r_div7;
        e_num1_reg   <= e_num;
        r_num1_reg   <= r_num;

        e_seg2_reg   <= e_seg1_reg;
        r_seg2_reg   <= r_seg1_reg;
        e_below2_reg <= e_below1_reg;
        e_above2_reg <= e_above1_reg;
        r_below2_reg <= r_below1_reg;
        r_above2_reg <= r_above1_reg;
        r_div72_reg  <= r_div71_reg;
        e_prod_reg   <= PROD_W'(e_num1_reg) * PROD_W'(RECIP3);
        r_prod_reg   <= PROD_W'(r_num1_reg) * PROD_W'(r_div71_reg ? RECIP7 : RECIP3);
    end

    // Memberships, cell strengths and rule codes.
    always_comb
    begin
        if (e_below2_reg)
        begin
            e_w0 = ONE_W;
        end
        else if (e_above2_reg)
        begin
            e_w0 = '0;
        end
        else
        begin
            e_w0 = W_W'(e_prod_reg >> SH3);
        end
        if (r_below2_reg)
        begin
            r_w0 = ONE_W;
        end
        else if (r_above2_reg)
        begin
            r_w0 = '0;
        end
        else if (r_div72_reg)
        begin
            r_w0 = W_W'(r_prod_reg >> SH7);
        end
        else
        begin
            r_w0 = W_W'(r_prod_reg >> SH3);
        end
        e_w1 = ONE_W - e_w0;
        r_w1 = ONE_W - r_w0;
        s_calc[0] = (e_w0 <= r_w0) ? e_w0 : r_w0;
        s_calc[1] = (e_w1 <= r_w0) ? e_w1 : r_w0;
        s_calc[2] = (e_w0 <= r_w1) ? e_w0 : r_w1;
        s_calc[3] = (e_w1 <= r_w1) ? e_w1 : r_w1;
        c_calc[0] = RULE_MAP[e_seg2_reg][r_seg2_reg];
        c_calc[1] = RULE_MAP[e_seg2_reg + 1'b1][r_seg2_reg];
        c_calc[2] = RULE_MAP[e_seg2_reg][r_seg2_reg + 1'b1];
        c_calc[3] = RULE_MAP[e_seg2_reg + 1'b1][r_seg2_reg + 1'b1];
    end

    always_ff @(posedge clk)
    begin
        s3_reg <= s_calc;
        c3_reg <= c_calc;
    end

    // Cells that share a code keep only the strongest; a tie goes to the later cell.
    always_comb
    begin
        s_kept = s3_reg;
        for (int i = 0; i < N_CELLS - 1; i++)
        begin
            for (int j = i + 1; j < N_CELLS; j++)
            begin
                if (c3_reg[i] == c3_reg[j])
                begin
                    if (s_kept[i] > s_kept[j])
                    begin
                        s_kept[j] = '0;
                    end
                    else
                    begin
                        s_kept[i] = '0;
                    end
                end
            end
        end
    end

    assign out_push          = v3_reg;
    assign out_item.code     = c3_reg;
    assign out_item.strength = s_kept;

endmodule

`default_nettype wire

>>> src/fpd_back.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller back end
// Holds the output levels and forms the weighted average with a pipelined divider.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fpd_pkg::cfg_write_t           cfg,
    input  fpd_pkg::fpd_item_t            mid_item,
    input  logic                          mid_empty,
    output logic                          mid_pop,
    input  logic                          out_full,
    output logic                          out_push,
    output logic [fpd_pkg::DRIVE_W-1:0]   out_drive
);
    import fpd_pkg::*;

    localparam int DEN_W      = W_W + 2;
    localparam int PP_W       = W_W + LEVEL_W;
    localparam int SUM_W      = PP_W + 3;
    localparam int REM_W      = SUM_W + OUT_FRAC;
    localparam int DIV_STAGES = DRIVE_W;

    logic [LEVEL_W-1:0]  level_reg [N_LEVELS];
    logic                adv;

    // Per-code weights.
    logic [N_LEVELS-1:0][W_W-1:0] wc;
    logic [DEN_W-1:0]    den_calc;
    logic                b1_v_reg;
    logic [N_LEVELS-1:0][W_W-1:0] wc_reg;
    logic [DEN_W-1:0]    den1_reg;

    // Products.
    logic                b2_v_reg;
    logic [N_LEVELS-1:0][PP_W-1:0] pp_reg;
    logic [DEN_W-1:0]    den2_reg;

    // Numerator.
    logic [SUM_W-1:0]    num_calc;
    logic                b3_v_reg;
    logic [SUM_W-1:0]    num3_reg;
    logic [DEN_W-1:0]    den3_reg;

    // Divider stages.
    logic                dv_v_reg  [DIV_STAGES];
    logic [REM_W-1:0]    rem_reg   [DIV_STAGES];
    logic [DEN_W-1:0]    dden_reg  [DIV_STAGES];
    logic [DRIVE_W-1:0]  q_reg     [DIV_STAGES];
    logic                src_v     [DIV_STAGES];
    logic [REM_W-1:0]    src_rem   [DIV_STAGES];
    logic [DEN_W-1:0]    src_den   [DIV_STAGES];
    logic [DRIVE_W-1:0]  src_q     [DIV_STAGES];

    // The whole back end holds while a finished result cannot enter the output queue.
    assign adv     = !(dv_v_reg[DIV_STAGES-1] && out_full);
    assign mid_pop = adv && !mid_empty;

    // Output level registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < N_LEVELS; c++)
            begin
                level_reg[c] <= LEVEL_RESET[c];
            end
        end
        else if (cfg.en)
        begin
            for (int c = 0; c < N_LEVELS; c++)
            begin
                if (cfg.index == REG_IDX_W'(c))
                begin
                    level_reg[c] <= cfg.data;
                end
            end
        end
    end

    // At most one surviving cell carries each code, so its weight is an OR.
    always_comb
    begin
        den_calc = '0;
        for (int c = 0; c < N_LEVELS; c++)
        begin
            wc[c] = '0;
            for (int i = 0; i < N_CELLS; i++)
            begin
                if (mid_item.code[i] == CODE_W'(c))
                begin
                    wc[c] = wc[c] | mid_item.strength[i];
                end
            end
        end
        for (int i = 0; i < N_CELLS; i++)
        begin
            den_calc = den_calc + DEN_W'(mid_item.strength[i]);
        end
    end

    always_comb
    begin
        num_calc = '0;
        for (int c = 0; c < N_LEVELS; c++)
        begin
            num_calc = num_calc + SUM_W'(pp_reg[c]);
        end
    end

    // Valid bits of the accumulate stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_v_reg <= mid_pop;
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
        end
    end

    // Weights, products and numerator sum.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wc_reg   <= wc;
            den1_reg <= den_calc;
            for (int c = 0; c < N_LEVELS; c++)
            begin
                pp_reg[c] <= PP_W'(wc_reg[c]) * PP_W'(level_reg[c]);
            end
            den2_reg <= den1_reg;
            num3_reg <= num_calc;
            den3_reg <= den2_reg;
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_div
            localparam int BIT = DIV_STAGES - 1 - k;
            logic [REM_W-1:0] trial;
            logic             ge;

            if (k == 0)
            begin : g_first
                assign src_v[k]   = b3_v_reg;
                assign src_rem[k] = REM_W'(num3_reg) << OUT_FRAC;
                assign src_den[k] = den3_reg;
                assign src_q[k]   = '0;
            end
            else
            begin : g_rest
                assign src_v[k]   = dv_v_reg[k-1];
                assign src_rem[k] = rem_reg[k-1];
                assign src_den[k] = dden_reg[k-1];
                assign src_q[k]   = q_reg[k-1];
            end

            assign trial = REM_W'(src_den[k]) << BIT;
            assign ge    = (src_rem[k] >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_v_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_v_reg[k] <= src_v[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k]  <= ge ? (src_rem[k] - trial) : src_rem[k];
                    dden_reg[k] <= src_den[k];
                    q_reg[k]    <= src_q[k] | (ge ? (DRIVE_W'(1) << BIT) : '0);
                end
            end
        end
    endgenerate

    // A zero divisor cannot arise from the table, but would give zero drive.
    assign out_push  = adv && dv_v_reg[DIV_STAGES-1];
    assign out_drive = (dden_reg[DIV_STAGES-1] == '0) ? '0 : q_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> src/fuzzy_pd_controller_top.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller
// Accepts one error/rate request per cycle while full is low and returns one
// drive value for it, in order. The front end fuzzifies the two inputs, forms
// the four rule cell strengths and drops duplicate codes; a queue of eight
// entries then feeds the back end, which weights the seven configurable output
// levels and divides through a sixteen-stage restoring divider, one quotient
// bit per stage. That divider sets most of the latency. The level registers
// are written at any cycle with wr_en; they should only change while no
// request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fuzzy_pd_controller_top_macros.svh"

module fuzzy_pd_controller_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [fpd_pkg::IN_W-1:0]     error,
    input  logic signed [fpd_pkg::IN_W-1:0]     error_rate,
    output logic                                empty,
    input  logic                                pop,
    output logic [fpd_pkg::DRIVE_W-1:0]         drive,
    input  logic                                wr_en,
    input  logic [fpd_pkg::REG_IDX_W-1:0]       wr_index,
    input  logic [fpd_pkg::LEVEL_W-1:0]         wr_data
);
    import fpd_pkg::*;

    localparam int CRED_W = $clog2(MID_DEPTH + 1);

    logic                 accept;
    logic                 front_push;
    fpd_item_t            front_item;
    fpd_item_t            mid_item;
    logic                 mid_empty;
    logic                 mid_full;
    logic                 mid_pop;
    logic                 out_push;
    logic                 out_full;
    logic [DRIVE_W-1:0]   out_drive;
    cfg_write_t           cfg;
    logic [CRED_W-1:0]    inflight_reg, inflight_next;

    assign cfg.en    = wr_en;
    assign cfg.index = wr_index;
    assign cfg.data  = wr_data;

    // Requests in the front end or the middle queue; the queue always has room for them.
    assign accept = push && !full;
    assign full   = (inflight_reg == CRED_W'(MID_DEPTH));

    always_comb
    begin
        inflight_next = inflight_reg;
        if (accept && !mid_pop)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (mid_pop && !accept)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // Front end.
    fpd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .error      (error),
        .error_rate (error_rate),
        .out_push   (front_push),
        .out_item   (front_item)
    );

    // Queue between front and back.
    fpd_fifo
    #(
        .WIDTH ($bits(fpd_item_t)),
        .DEPTH (MID_DEPTH)
    )
    u_mid_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .din   (front_item),
        .pop   (mid_pop),
        .dout  (mid_item),
        .empty (mid_empty),
        .full  (mid_full)
    );

    // Back end.
    fpd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .mid_item  (mid_item),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_drive (out_drive)
    );

    // Result queue.
    fpd_fifo
    #(
        .WIDTH (DRIVE_W),
        .DEPTH (OUT_DEPTH)
    )
    u_out_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_drive),
        .pop   (pop),
        .dout  (drive),
        .empty (empty),
        .full  (out_full)
    );

    // Checks on the credit scheme and the queue hand-offs.
    `FPD_ASSERT_SAME(a_credit_bound, 1'b1, inflight_reg <= CRED_W'(MID_DEPTH), "credit overflow")
    `FPD_ASSERT_SAME(a_mid_room, front_push, !mid_full, "middle queue overrun")
    `FPD_ASSERT_SAME(a_out_room, out_push, !out_full, "result queue overrun")
    `FPD_ASSERT_NEXT(a_credit_step, accept && !mid_pop, inflight_reg == $past(inflight_reg) + 1'b1, "credit not taken")

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fuzzy PD controller testbench
// Sends error/rate requests through the push/full side, predicts each drive
// value from the fuzzy rule table and the current output levels, and checks
// every popped result in order. Both sides stall in random bursts until the quiet phase.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import fpd_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 500;
    localparam int N_QUIET = 100;
    localparam logic [REG_IDX_W-1:0] IDX_UNUSED = REG_IDX_W'(N_LEVELS);

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic signed [IN_W-1:0] error;
    logic signed [IN_W-1:0] error_rate;
    logic empty;
    logic pop;
    logic [DRIVE_W-1:0] drive;
    logic wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [LEVEL_W-1:0] wr_data;

    // Shadow copy of the output levels and the expected drive values.
    logic [LEVEL_W-1:0] level_shadow [N_LEVELS];
    logic [DRIVE_W-1:0] drive_expected_q [$];

    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    int pop_stall = 0;

    fuzzy_pd_controller_top u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .error      (error),
        .error_rate (error_rate),
        .empty      (empty),
        .pop        (pop),
        .drive      (drive),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    // Clock.
    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // Picks the segment of a value and returns the weight of its lower point.
    function automatic void fuzzify(input int x, input bit is_err,
                                    output int seg, output longint w_low);
        int n;
        int pts [N_ERR];
        int k;
        n = is_err ? N_ERR : N_RATE;
        for (k = 0; k < N_ERR; k++)
        begin
            if (is_err)
                pts[k] = ERR_PTS[k];
            else if (k < N_RATE)
                pts[k] = RATE_PTS[k];
        end
        if (x <= pts[0])
        begin
            seg = 0;
            w_low = longint'(1) << WF;
        end
        else if (x >= pts[n-1])
        begin
            seg = n - 2;
            w_low = 0;
        end
        else
        begin
            for (k = 0; k < n - 2; k++)
                if (x <= pts[k+1])
                    break;
            seg = k;
            w_low = (longint'(pts[k+1] - x) << WF) / longint'(pts[k+1] - pts[k]);
        end
    endfunction

    // Weighted average of the output levels over the surviving rule cells.
    function automatic logic [DRIVE_W-1:0] predict_drive(input int e, input int r);
        int es, rs, i, j;
        longint e0, e1, r0, r1, num, den;
        longint s [4];
        int code [4];
        fuzzify(e, 1'b1, es, e0);
        fuzzify(r, 1'b0, rs, r0);
        e1 = (longint'(1) << WF) - e0;
        r1 = (longint'(1) << WF) - r0;
        code[0] = RULE_MAP[es][rs];
        code[1] = RULE_MAP[es+1][rs];
        code[2] = RULE_MAP[es][rs+1];
        code[3] = RULE_MAP[es+1][rs+1];
        s[0] = (e0 <= r0) ? e0 : r0;
        s[1] = (e1 <= r0) ? e1 : r0;
        s[2] = (e0 <= r1) ? e0 : r1;
        s[3] = (e1 <= r1) ? e1 : r1;
        // Cells naming the same level: the later one wins unless strictly weaker.
        for (i = 0; i < 3; i++)
            for (j = i + 1; j < 4; j++)
                if (code[i] == code[j])
                begin
                    if (s[i] > s[j])
                        s[j] = 0;
                    else
                        s[i] = 0;
                end
        num = 0;
        den = 0;
        for (i = 0; i < 4; i++)
        begin
            num += s[i] * longint'(level_shadow[code[i]]);
            den += s[i];
        end
        if (den == 0)
            return '0;
        return DRIVE_W'((num << OUT_FRAC) / den);
    endfunction

    // Sends one request; called at a rising edge and returns at one.
    task automatic send_request(input int e, input int r);
        int gap;
        push <= 1'b1;
        error <= IN_W'(e);
        error_rate <= IN_W'(r);
        do
            @(posedge clk);
        while (full);
        drive_expected_q.push_back(predict_drive(e, r));
        n_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Writes one level register; only called while nothing is in flight.
    // The caller drops wr_en after the last write of a batch.
    task automatic write_level(input logic [REG_IDX_W-1:0] idx,
                               input logic [LEVEL_W-1:0] value);
        push <= 1'b0;
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(posedge clk);
        if (idx < N_LEVELS)
            level_shadow[idx] = value;
    endtask

    // Waits until every expected result has come, then lets the pipeline settle.
    task automatic drain;
        push <= 1'b0;
        while (drive_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Breakpoints, range ends, extremes of the fields and tied strengths.
    task automatic test_directed;
        int k;
        for (k = 0; k < N_ERR; k++)
            send_request(ERR_PTS[k], RATE_PTS[k % N_RATE]);
        for (k = 0; k < N_RATE; k++)
            send_request(ERR_PTS[N_ERR-1-k] + 1, RATE_PTS[k] - 1);
        send_request(-32768, -32768);
        send_request(32767, 32767);
        send_request(-32768, 32767);
        send_request(32767, -32768);
        send_request(0, 0);
        send_request(-1, 1);
        send_request(768, 384);
        send_request(-768, -384);
        send_request(-2304, -1216);
        send_request(4608, 1216);
        send_request(2304, 0);
        send_request(-4608, 384);
        send_request(-6143, 1663);
        drain();
    endtask

    // Level settings, including the extremes and an unused register index.
    task automatic test_levels;
        int k, p, n;
        for (p = 0; p < 4; p++)
        begin
            for (k = 0; k < N_LEVELS; k++)
            begin
                case (p)
                    0: write_level(REG_IDX_W'(k), '0);
                    1: write_level(REG_IDX_W'(k), '1);
                    2: write_level(REG_IDX_W'(k), (k % 2) ? '1 : '0);
                    default: write_level(REG_IDX_W'(k), LEVEL_W'($urandom));
                endcase
            end
            write_level(IDX_UNUSED, LEVEL_W'($urandom));
            wr_en <= 1'b0;
            @(posedge clk);
            for (n = 0; n < 20; n++)
                send_request($urandom_range(0, 14000) - 7000,
                             $urandom_range(0, 4000) - 2000);
            drain();
        end
    endtask

    // Random requests, mostly inside the breakpoint ranges.
    task automatic test_random(input int count);
        int n, e, r;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                e = $urandom_range(0, 14000) - 7000;
                r = $urandom_range(0, 4000) - 2000;
            end
            else
            begin
                e = $signed(IN_W'($urandom));
                r = $signed(IN_W'($urandom));
            end
            send_request(e, r);
        end
        drain();
    endtask

    // Result side: random pop stalls and the in-order check.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (drive_expected_q.size() == 0)
            begin
                $error("drive: result 0x%04h with no request outstanding", drive);
                n_errors++;
            end
            else
            begin
                if (drive !== drive_expected_q[0])
                begin
                    $error("drive mismatch: expected 0x%04h, actual 0x%04h",
                           drive_expected_q[0], drive);
                    n_errors++;
                end
                void'(drive_expected_q.pop_front());
                n_checked++;
            end
        end
        if (pop_stall > 0)
        begin
            pop_stall--;
            pop <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            pop_stall = $urandom_range(1, 11) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // Watchdog on cycles in which neither side accepts anything.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Sequence of tests.
    initial
    begin
        int k;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        error = '0;
        error_rate = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        for (k = 0; k < N_LEVELS; k++)
            level_shadow[k] = LEVEL_RESET[k];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_levels();
        test_random(N_RANDOM - N_QUIET);
        quiet = 1;
        test_random(N_QUIET);

        $display("Covered %0d requests and %0d checked drive values,", n_sent, n_checked);
        $display("over reset, extreme and random output levels with stalls on both sides.");
        if (n_errors == 0 && drive_expected_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
